// ===== hdl/psl_pkg.sv =====
// Package: shared types, codes and constants of the power state load shed controller.
package psl_pkg;

  localparam int unsigned BusCount      = 3;
  localparam int unsigned EnergyWidth   = 48;
  localparam int unsigned VoltWidth     = 16;
  localparam int unsigned CurrWidth     = 13;
  localparam int unsigned SumWidth      = 15;
  localparam int unsigned PowerWidth    = 31;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [EnergyWidth-1:0] EnergyMax = {EnergyWidth{1'b1}};

  localparam logic [VoltWidth-1:0] LowThrReset  = 16'd10500;
  localparam logic [VoltWidth-1:0] CritThrReset = 16'd9600;
  localparam logic [BusCount-1:0]  EnablesReset = {BusCount{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_SET_BUS  = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_NOMINAL  = 2'd0,
    MODE_LOW      = 2'd1,
    MODE_CRITICAL = 2'd2,
    MODE_SAFE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BUS_PRIMARY = 2'd0,
    BUS_PLD     = 2'd1,
    BUS_HTR     = 2'd2,
    BUS_INVALID = 2'd3
  } bus_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LOW_THR  = 2'd0,
    REG_CRIT_THR = 2'd1,
    REG_SPARE2   = 2'd2,
    REG_SPARE3   = 2'd3
  } reg_e;

  typedef struct packed {
    op_e                  op;
    logic [VoltWidth-1:0] voltage_mv;
    logic [CurrWidth-1:0] primary_ma;
    logic [CurrWidth-1:0] payload_ma;
    logic [CurrWidth-1:0] heater_ma;
    mode_e                new_mode;
    bus_e                 bus_index;
    logic                 bus_enable;
  } req_t;

  typedef struct packed {
    mode_e                  mode;
    logic [BusCount-1:0]    enables;
    logic [EnergyWidth-1:0] energy;
  } state_t;

  typedef struct packed {
    logic [VoltWidth-1:0] low_thr;
    logic [VoltWidth-1:0] crit_thr;
  } thr_t;

  typedef struct packed {
    mode_e                  mode;
    logic [BusCount-1:0]    enables;
    logic [PowerWidth-1:0]  power_uw;
    logic [EnergyWidth-1:0] energy;
    logic                   status;
    logic                   low_event;
    logic                   critical_event;
  } res_t;

endpackage

// ===== hdl/psl_calc.sv =====
// Next state and result of one request, from the current state and thresholds.
module psl_calc (
  input  psl_pkg::req_t   req_i,
  input  psl_pkg::state_t state_i,
  input  psl_pkg::thr_t   thr_i,
  output psl_pkg::state_t state_o,
  output psl_pkg::res_t   res_o
);

  logic [psl_pkg::SumWidth-1:0]      cur_sum;
  logic [psl_pkg::PowerWidth-1:0]    power;
  logic [psl_pkg::EnergyWidth:0]     energy_add;
  logic [psl_pkg::EnergyWidth-1:0]   energy_sat;
  logic                              below_crit;
  logic                              below_low;

  // Sum only enabled buses.
  always_comb begin
    cur_sum = '0;
    if (state_i.enables[0]) begin
      cur_sum = cur_sum + psl_pkg::SumWidth'(req_i.primary_ma);
    end
    if (state_i.enables[1]) begin
      cur_sum = cur_sum + psl_pkg::SumWidth'(req_i.payload_ma);
    end
    if (state_i.enables[2]) begin
      cur_sum = cur_sum + psl_pkg::SumWidth'(req_i.heater_ma);
    end
  end

  assign power = psl_pkg::PowerWidth'(req_i.voltage_mv) * psl_pkg::PowerWidth'(cur_sum);

  // Carry out of the wide add means the accumulator saturates.
  assign energy_add = {1'b0, state_i.energy} + (psl_pkg::EnergyWidth + 1)'(power);
  assign energy_sat = energy_add[psl_pkg::EnergyWidth] ? psl_pkg::EnergyMax
                                                      : energy_add[psl_pkg::EnergyWidth-1:0];

  assign below_crit = req_i.voltage_mv < thr_i.crit_thr;
  assign below_low  = req_i.voltage_mv < thr_i.low_thr;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (req_i.op)
      psl_pkg::OP_TICK: begin
        res_o.power_uw = power;
        state_o.energy = energy_sat;
        if (below_crit && state_i.mode != psl_pkg::MODE_SAFE) begin
          state_o.mode         = psl_pkg::MODE_SAFE;
          res_o.critical_event = 1'b1;
        end else if (below_low && state_i.mode == psl_pkg::MODE_NOMINAL) begin
          state_o.mode    = psl_pkg::MODE_LOW;
          res_o.low_event = 1'b1;
        end
      end
      psl_pkg::OP_SET_MODE: begin
        state_o.mode = req_i.new_mode;
        // Shed payload in low and critical, heater in critical and safe.
        if (req_i.new_mode == psl_pkg::MODE_LOW ||
            req_i.new_mode == psl_pkg::MODE_CRITICAL) begin
          state_o.enables[1] = 1'b0;
        end
        if (req_i.new_mode == psl_pkg::MODE_CRITICAL ||
            req_i.new_mode == psl_pkg::MODE_SAFE) begin
          state_o.enables[2] = 1'b0;
        end
      end
      psl_pkg::OP_SET_BUS: begin
        case (req_i.bus_index)
          psl_pkg::BUS_PRIMARY: state_o.enables[0] = req_i.bus_enable;
          psl_pkg::BUS_PLD:     state_o.enables[1] = req_i.bus_enable;
          psl_pkg::BUS_HTR:     state_o.enables[2] = req_i.bus_enable;
          default:              res_o.status       = 1'b1;
        endcase
      end
      psl_pkg::OP_CLEAR: begin
        state_o.energy = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    res_o.mode    = state_o.mode;
    res_o.enables = state_o.enables;
    res_o.energy  = state_o.energy;
  end

endmodule

// ===== hdl/power_state_load_shed_controller.sv =====
// Top level: request and result registers, state, thresholds and configuration port.
//
// Usage:
//   Requests enter on the in_valid_i / in_ready_o channel, one field per port.
//   op_i selects tick (power and energy update, voltage thresholds), set mode,
//   set bus enable or clear energy. Every request yields exactly one result on
//   the out_valid_o / out_ready_i channel.
//   Path: an accepted request sits in the request register; once the result
//   register is free it is evaluated against the live state and its result
//   is loaded into the result register, which drives out_valid_o.
//   Throughput: one request per cycle while results are taken; the 16 x 15 bit
//   power multiply and 48 bit saturating accumulate are combinational in between.
//   Stall: while a result waits on out_ready_i the request register may still
//   take one more request; then in_ready_o drops until the result is taken.
//   Reset: mode nominal, all three buses on, energy zero, thresholds 10500 mV
//   and 9600 mV, both channels empty.
//   Configuration: write thresholds through cfg_we_i while idle; index 0 is
//   the low threshold, index 1 the critical threshold, other indexes are dropped.
module power_state_load_shed_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [psl_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [psl_pkg::CfgDataWidth-1:0]    cfg_wdata_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [psl_pkg::VoltWidth-1:0]       voltage_mv_i,
  input  logic [psl_pkg::CurrWidth-1:0]       primary_current_ma_i,
  input  logic [psl_pkg::CurrWidth-1:0]       payload_current_ma_i,
  input  logic [psl_pkg::CurrWidth-1:0]       heater_current_ma_i,
  input  logic [1:0]                          new_mode_i,
  input  logic [1:0]                          bus_index_i,
  input  logic                                bus_enable_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          mode_o,
  output logic [psl_pkg::BusCount-1:0]        enables_o,
  output logic [psl_pkg::PowerWidth-1:0]      total_power_uw_o,
  output logic [psl_pkg::EnergyWidth-1:0]     energy_total_o,
  output logic                                status_o,
  output logic                                low_event_o,
  output logic                                critical_event_o
);

  psl_pkg::req_t   req_q;
  logic            req_valid_q;
  psl_pkg::res_t   res_d, res_q;
  logic            res_valid_q;
  psl_pkg::state_t state_d, state_q;
  psl_pkg::thr_t   thr_q;
  logic            fire;
  logic            take;

  // Evaluate the held request once the result register is free.
  assign fire       = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || fire;
  assign take       = in_valid_i && in_ready_o;

  // Hold the incoming request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (take) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.op         <= psl_pkg::op_e'(op_i);
      req_q.voltage_mv <= voltage_mv_i;
      req_q.primary_ma <= primary_current_ma_i;
      req_q.payload_ma <= payload_current_ma_i;
      req_q.heater_ma  <= heater_current_ma_i;
      req_q.new_mode   <= psl_pkg::mode_e'(new_mode_i);
      req_q.bus_index  <= psl_pkg::bus_e'(bus_index_i);
      req_q.bus_enable <= bus_enable_i;
    end
  end

  psl_calc u_calc (
    .req_i   (req_q),
    .state_i (state_q),
    .thr_i   (thr_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Advance the controller state one request at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= psl_pkg::MODE_NOMINAL;
      state_q.enables <= psl_pkg::EnablesReset;
      state_q.energy  <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Threshold registers; writes to spare indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.low_thr  <= psl_pkg::LowThrReset;
      thr_q.crit_thr <= psl_pkg::CritThrReset;
    end else if (cfg_we_i) begin
      case (psl_pkg::reg_e'(cfg_index_i))
        psl_pkg::REG_LOW_THR:  thr_q.low_thr  <= cfg_wdata_i;
        psl_pkg::REG_CRIT_THR: thr_q.crit_thr <= cfg_wdata_i;
        default:               thr_q          <= thr_q;
      endcase
    end
  end

  // Result register: load on evaluation, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign mode_o           = res_q.mode;
  assign enables_o        = res_q.enables;
  assign total_power_uw_o = res_q.power_uw;
  assign energy_total_o   = res_q.energy;
  assign status_o         = res_q.status;
  assign low_event_o      = res_q.low_event;
  assign critical_event_o = res_q.critical_event;

endmodule

// ===== hdl/psl_checker.sv =====
// Checker on the top level ports, bound to the power state load shed controller.
module psl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      mode_o,
  input logic [psl_pkg::PowerWidth-1:0]  total_power_uw_o,
  input logic                            status_o,
  input logic                            low_event_o,
  input logic                            critical_event_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_crit_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && critical_event_o |-> mode_o == psl_pkg::MODE_SAFE && !low_event_o)
    else $error("critical event without safe mode");

  a_low_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && low_event_o |-> mode_o == psl_pkg::MODE_LOW)
    else $error("low event without low power mode");

  a_status_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> total_power_uw_o == '0 && !low_event_o && !critical_event_o)
    else $error("bus index error on a tick result");

endmodule

bind power_state_load_shed_controller psl_checker u_psl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .mode_o           (mode_o),
  .total_power_uw_o (total_power_uw_o),
  .status_o         (status_o),
  .low_event_o      (low_event_o),
  .critical_event_o (critical_event_o)
);

// ===== tb/sv/load_shed_tb_pkg.sv =====
// Scoreboard for the power state load shed controller: state tracking and result checks.
`timescale 1ns / 1ps
package load_shed_tb_pkg;
  import psl_pkg::*;

  class load_shed_scoreboard;
    mode_e                  pwr_mode;
    logic [BusCount-1:0]    bus_on;
    logic [EnergyWidth-1:0] energy_acc;
    logic [VoltWidth-1:0]   low_thr;
    logic [VoltWidth-1:0]   crit_thr;
    res_t                   expected_q[$];
    int unsigned            n_requests;
    int unsigned            n_ticks;
    int unsigned            n_checked;
    int unsigned            n_errors;
    int unsigned            n_low;
    int unsigned            n_crit;
    int unsigned            n_bad_bus;
    int unsigned            n_saturated;

    function new();
      pwr_mode   = MODE_NOMINAL;
      bus_on     = EnablesReset;
      energy_acc = '0;
      low_thr    = LowThrReset;
      crit_thr   = CritThrReset;
    endfunction

    // Spare indexes fall through and leave both thresholds alone.
    function void set_threshold(reg_e idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_LOW_THR:  low_thr = data;
        REG_CRIT_THR: crit_thr = data;
        default: ;
      endcase
    endfunction

    function void note_request(req_t rq);
      logic [63:0] amps;
      logic [63:0] pwr;
      res_t        exp;
      exp  = '0;
      amps = '0;
      pwr  = '0;
      n_requests++;
      case (rq.op)
        OP_TICK: begin
          n_ticks++;
          if (bus_on[BUS_PRIMARY]) amps += 64'(rq.primary_ma);
          if (bus_on[BUS_PLD])     amps += 64'(rq.payload_ma);
          if (bus_on[BUS_HTR])     amps += 64'(rq.heater_ma);
          pwr = 64'(rq.voltage_mv) * amps;
          if (64'(energy_acc) > 64'(EnergyMax) - pwr) begin
            energy_acc = EnergyMax;
            n_saturated++;
          end else begin
            energy_acc = energy_acc + pwr[EnergyWidth-1:0];
          end
          // critical wins over low; neither sheds any load
          if (rq.voltage_mv < crit_thr && pwr_mode != MODE_SAFE) begin
            pwr_mode = MODE_SAFE;
            exp.critical_event = 1'b1;
            n_crit++;
          end else if (rq.voltage_mv < low_thr && pwr_mode == MODE_NOMINAL) begin
            pwr_mode = MODE_LOW;
            exp.low_event = 1'b1;
            n_low++;
          end
        end
        OP_SET_MODE: begin
          pwr_mode = rq.new_mode;
          if (pwr_mode inside {MODE_LOW, MODE_CRITICAL}) bus_on[BUS_PLD] = 1'b0;
          if (pwr_mode inside {MODE_CRITICAL, MODE_SAFE}) bus_on[BUS_HTR] = 1'b0;
        end
        OP_SET_BUS: begin
          if (rq.bus_index == BUS_INVALID) begin
            exp.status = 1'b1;
            n_bad_bus++;
          end else begin
            bus_on[rq.bus_index] = rq.bus_enable;
          end
        end
        OP_CLEAR: energy_acc = '0;
        default: ;
      endcase
      exp.mode     = pwr_mode;
      exp.enables  = bus_on;
      exp.power_uw = pwr[PowerWidth-1:0];
      exp.energy   = energy_acc;
      expected_q.push_back(exp);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        n_errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        n_errors++;
        return;
      end
      exp = expected_q.pop_front();
      n_checked++;
      compare("mode", exp.mode, got.mode);
      compare("enables", exp.enables, got.enables);
      compare("total_power_uw", exp.power_uw, got.power_uw);
      compare("energy_total", exp.energy, got.energy);
      compare("status", exp.status, got.status);
      compare("low_event", exp.low_event, got.low_event);
      compare("critical_event", exp.critical_event, got.critical_event);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// Testbench top: drives requests and thresholds into the load shed controller and checks results.
`timescale 1ns / 1ps
module tb;
  import psl_pkg::*;
  import load_shed_tb_pkg::*;

  localparam int unsigned ClkHalf        = 5;
  localparam int unsigned ResetCycles    = 12;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned HoldOffCycles  = 80;
  localparam int unsigned DrainSlack     = 4;
  localparam int unsigned EndSlack       = 8;
  // Short run of full power ticks sent back to back.
  localparam int unsigned FullPowerTicks = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_wdata = '0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t drv_req  = '0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             mode_q;
  logic [BusCount-1:0]    enables_q;
  logic [PowerWidth-1:0]  power_q;
  logic [EnergyWidth-1:0] energy_q;
  logic                   status_q;
  logic                   low_ev_q;
  logic                   crit_ev_q;

  // Stimulus knobs shared between the sender and the receiver.
  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;

  int unsigned quiet_cycles = 0;

  load_shed_scoreboard sb;

  always #ClkHalf clk = ~clk;

  power_state_load_shed_controller u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .op_i                (drv_req.op),
    .voltage_mv_i        (drv_req.voltage_mv),
    .primary_current_ma_i(drv_req.primary_ma),
    .payload_current_ma_i(drv_req.payload_ma),
    .heater_current_ma_i (drv_req.heater_ma),
    .new_mode_i          (drv_req.new_mode),
    .bus_index_i         (drv_req.bus_index),
    .bus_enable_i        (drv_req.bus_enable),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .mode_o              (mode_q),
    .enables_o           (enables_q),
    .total_power_uw_o    (power_q),
    .energy_total_o      (energy_q),
    .status_o            (status_q),
    .low_event_o         (low_ev_q),
    .critical_event_o    (crit_ev_q)
  );

  // ---------------------------------------------------------------------------
  // Request builders. Fields a request does not use are filled at random so
  // that the block is seen to ignore them.
  // ---------------------------------------------------------------------------
  function automatic req_t make_tick(logic [VoltWidth-1:0] volt, logic [CurrWidth-1:0] pri,
                                     logic [CurrWidth-1:0] pay, logic [CurrWidth-1:0] htr);
    req_t rq;
    rq.op         = OP_TICK;
    rq.voltage_mv = volt;
    rq.primary_ma = pri;
    rq.payload_ma = pay;
    rq.heater_ma  = htr;
    rq.new_mode   = mode_e'($urandom_range(0, 3));
    rq.bus_index  = bus_e'($urandom_range(0, 3));
    rq.bus_enable = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic req_t make_cmd(op_e cmd, mode_e m, bus_e b, logic en);
    req_t rq;
    rq.op         = cmd;
    rq.voltage_mv = 16'($urandom_range(0, 65535));
    rq.primary_ma = 13'($urandom_range(0, 8191));
    rq.payload_ma = 13'($urandom_range(0, 8191));
    rq.heater_ma  = 13'($urandom_range(0, 8191));
    rq.new_mode   = m;
    rq.bus_index  = b;
    rq.bus_enable = en;
    return rq;
  endfunction

  // Aim a good share of voltages at the live thresholds, up to two either side
  // and right on them, so that both comparisons flip often.
  function automatic logic [VoltWidth-1:0] pick_voltage();
    case ($urandom_range(0, 5))
      0: return sb.low_thr + 16'($urandom_range(0, 4)) - 16'd2;
      1: return sb.crit_thr + 16'($urandom_range(0, 4)) - 16'd2;
      2: return '0;
      3: return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CurrWidth-1:0] pick_current();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  // Mostly ticks; mode commands come often enough to pull the mode back to
  // nominal and re-arm the low power demotion.
  function automatic req_t random_request();
    int unsigned pick;
    op_e         cmd;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return make_tick(pick_voltage(), pick_current(), pick_current(), pick_current());
    cmd = (pick < 72) ? OP_SET_MODE : (pick < 90) ? OP_SET_BUS : OP_CLEAR;
    return make_cmd(cmd, mode_e'($urandom_range(0, 3)), bus_e'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. Everything changes at the falling edge; handshakes are
  // sampled at the rising edge. Valid is never lowered between two requests
  // sent back to back.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t rq);
    @(negedge clk);
    in_valid <= 1'b1;
    drv_req  <= rq;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  // Drop valid and hold until every outstanding result is back, then let the
  // pipeline settle before anything touches the thresholds.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic program_reg(input reg_e idx, input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_threshold(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned gap;
    for (int unsigned i = 0; i < count; i++) begin
      // insert a sender gap now and then
      if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      send_request(random_request());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready stalls in random bursts while idling is on, and holds off
  // for a long stretch on request so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor: check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.mode           = mode_e'(mode_q);
      got.enables        = enables_q;
      got.power_uw       = power_q;
      got.energy         = energy_q;
      got.status         = status_q;
      got.low_event      = low_ev_q;
      got.critical_event = crit_ev_q;
      sb.check_result(got);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", quiet_cycles);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk at the reset thresholds (10500 / 9600 mV), starting from
    // nominal with every bus on.
    send_request(make_tick(16'd12000, 13'd100, 13'd200, 13'd300));
    send_request(make_tick('1, '1, '1, '1));                     // largest power
    send_request(make_tick(16'd10500, 13'd1, 13'd1, 13'd1));     // on the low threshold
    send_request(make_tick(16'd10499, '0, '0, '0));              // demote to low power
    send_request(make_tick(16'd10000, 13'd5, 13'd6, 13'd7));     // already low: no event
    send_request(make_tick(16'd9600, 13'd5, 13'd6, 13'd7));      // on the critical threshold
    send_request(make_tick(16'd9599, 13'd8, 13'd9, 13'd10));     // low into safe
    send_request(make_tick('0, '1, '0, '1));                     // safe stays quiet
    send_request(make_cmd(OP_SET_MODE, MODE_NOMINAL, BUS_HTR, 1'b0));
    send_request(make_tick(16'd9000, 13'd50, 13'd60, 13'd70));   // critical beats low
    send_request(make_cmd(OP_SET_MODE, MODE_LOW, BUS_PRIMARY, 1'b1));
    send_request(make_tick(16'd20000, 13'd1000, 13'd4000, 13'd500));  // payload shed
    send_request(make_cmd(OP_SET_BUS, MODE_SAFE, BUS_PLD, 1'b1));
    send_request(make_cmd(OP_SET_MODE, MODE_CRITICAL, BUS_INVALID, 1'b0));
    send_request(make_tick(16'd5000, 13'd10, 13'd20, 13'd30));   // critical into safe
    send_request(make_cmd(OP_SET_MODE, MODE_SAFE, BUS_PLD, 1'b1));
    send_request(make_cmd(OP_SET_BUS, MODE_NOMINAL, BUS_INVALID, 1'b1));
    send_request(make_cmd(OP_SET_BUS, MODE_LOW, BUS_INVALID, 1'b0));
    send_request(make_cmd(OP_SET_BUS, MODE_CRITICAL, BUS_PRIMARY, 1'b0));
    send_request(make_tick(16'd30000, '1, '1, '1));              // every bus off
    send_request(make_cmd(OP_SET_BUS, MODE_NOMINAL, BUS_PLD, 1'b1));
    send_request(make_cmd(OP_SET_BUS, MODE_SAFE, BUS_HTR, 1'b1));
    send_request(make_cmd(OP_SET_BUS, MODE_LOW, BUS_PRIMARY, 1'b1));
    send_request(make_cmd(OP_CLEAR, MODE_CRITICAL, BUS_HTR, 1'b0));
    send_request(make_cmd(OP_SET_MODE, MODE_NOMINAL, BUS_PRIMARY, 1'b0));

    // Full power ticks back to back, then check that clear empties the
    // accumulator.
    idle_on = 1'b0;
    repeat (FullPowerTicks) send_request(make_tick('1, '1, '1, '1));
    send_request(make_tick('1, '0, '0, '0));
    send_request(make_tick(16'd12000, 13'd3, 13'd2, 13'd1));
    send_request(make_cmd(OP_CLEAR, MODE_NOMINAL, BUS_PRIMARY, 1'b1));
    send_request(make_tick(16'd12000, 13'd3, 13'd2, 13'd1));
    idle_on = 1'b1;

    // Reset thresholds again, written explicitly; spare indexes must be dropped.
    wait_drained();
    program_reg(REG_LOW_THR, LowThrReset);
    program_reg(REG_CRIT_THR, CritThrReset);
    program_reg(REG_SPARE2, 16'($urandom_range(0, 65535)));
    program_reg(REG_SPARE3, 16'($urandom_range(0, 65535)));

    // Back-pressure: hold the receiver off while requests keep coming, so the
    // block fills and stalls its input.
    hold_off_req = 1'b1;
    idle_on      = 1'b0;
    run_random(30);
    idle_on = 1'b1;
    run_random(70);

    // Both thresholds at the top: nearly every tick forces safe mode.
    wait_drained();
    program_reg(REG_LOW_THR, '1);
    program_reg(REG_CRIT_THR, '1);
    run_random(60);

    // Both at zero: no tick can demote.
    wait_drained();
    program_reg(REG_LOW_THR, '0);
    program_reg(REG_CRIT_THR, '0);
    run_random(60);

    // Low threshold only.
    wait_drained();
    program_reg(REG_LOW_THR, '1);
    program_reg(REG_CRIT_THR, '0);
    run_random(60);

    // Critical above low.
    wait_drained();
    program_reg(REG_LOW_THR, 16'($urandom_range(0, 20000)));
    program_reg(REG_CRIT_THR, 16'($urandom_range(20001, 65535)));
    run_random(60);

    // Random thresholds, no idling on either side for the final stretch.
    wait_drained();
    program_reg(REG_LOW_THR, 16'($urandom_range(0, 65535)));
    program_reg(REG_CRIT_THR, 16'($urandom_range(0, 65535)));
    idle_on = 1'b0;
    run_random(80);

    wait_drained();
    repeat (EndSlack) @(posedge clk);

    $display("summary: %0d requests (%0d ticks), %0d results checked, %0d mismatches",
             sb.n_requests, sb.n_ticks, sb.n_checked, sb.n_errors);
    $display("summary: %0d low and %0d critical demotions, %0d bad bus indexes, %0d saturated",
             sb.n_low, sb.n_crit, sb.n_bad_bus, sb.n_saturated);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/psl_pkg.sv
hdl/psl_calc.sv
hdl/power_state_load_shed_controller.sv
hdl/psl_checker.sv
tb/sv/load_shed_tb_pkg.sv
tb/sv/tb.sv
